// ----- rtl/core/grc_pkg.sv -----
// Shared constants, datapath command codes and status types of the column renderer.
package grc_pkg;

	localparam int SCREEN_COLUMNS_DEF = 80;
	localparam int SCREEN_ROWS_DEF    = 25;
	localparam int MAP_COLUMNS_DEF    = 8;
	localparam int MAP_ROWS_DEF       = 3;

	localparam int COL_W   = 7;
	localparam int ANGLE_W = 16;
	localparam int POS_W   = 15;
	localparam int MAP_W   = 24;
	localparam int ROW_W   = 5;
	localparam int GLYPH_W = 8;
	localparam int COLOR_W = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Row counter must hold up to the largest supported screen height.
	localparam int ROW_CNT_W = 6;

	localparam int DIV_NUM_W = 20;
	localparam int DIV_DEN_W = 17;
	localparam int DIV_CNT_W = 5;

	localparam int ARG_W  = 23;
	localparam int TRIG_W = 17;
	localparam int DIST_W = 17;

	// Column angle offset table entry, column * ANG_ONE / SCREEN_COLUMNS.
	localparam int COL_OFS_W = 20;

	// Reciprocals: floor(x/6) for x < 2^17, floor(x/120) for x < 2^20.
	localparam int RECIP6      = 174763;
	localparam int RECIP6_SH   = 20;
	localparam int RECIP120    = 1118482;
	localparam int RECIP120_SH = 27;

	localparam int ANG_ONE   = 8192;
	localparam int ANG_HALF  = 4096;
	localparam int ANG_PI    = 25736;
	localparam int ANG_2PI   = 51472;
	localparam int ANG_QTURN = 12868;
	localparam int STEP_Q    = 410;
	localparam int FAR_Q     = 65536;
	localparam int CELL_ONE  = 4096;
	localparam int SHADE_NEAR = 16384;
	localparam int SHADE_MID  = 21845;
	localparam int SHADE_FAR  = 32768;

	localparam logic [GLYPH_W-1:0] GLYPH_SPACE = 8'h20;
	localparam logic [GLYPH_W-1:0] GLYPH_HASH  = 8'h23;
	localparam logic [GLYPH_W-1:0] GLYPH_BIGO  = 8'h4F;
	localparam logic [GLYPH_W-1:0] GLYPH_SMALLO = 8'h6F;
	localparam logic [GLYPH_W-1:0] GLYPH_DOT   = 8'h2E;
	localparam logic [COLOR_W-1:0] COLOR_SKY   = 4'd1;
	localparam logic [COLOR_W-1:0] COLOR_WALL  = 4'd15;
	localparam logic [COLOR_W-1:0] COLOR_FLOOR = 4'd8;

	localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP      = 2'd2;

	localparam logic [POS_W-1:0] PLAYER_X_RST = 15'd16384;
	localparam logic [POS_W-1:0] PLAYER_Y_RST = 15'd6144;
	localparam logic [MAP_W-1:0] MAP_RST      = 24'hFF91FF;

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NOP    = 4'd0;
	localparam logic [OP_W-1:0] OP_LOAD   = 4'd1;
	localparam logic [OP_W-1:0] OP_ANG    = 4'd2;
	localparam logic [OP_W-1:0] OP_RED    = 4'd3;
	localparam logic [OP_W-1:0] OP_SQR    = 4'd4;
	localparam logic [OP_W-1:0] OP_FOURTH = 4'd5;
	localparam logic [OP_W-1:0] OP_Q120   = 4'd6;
	localparam logic [OP_W-1:0] OP_POLY   = 4'd7;
	localparam logic [OP_W-1:0] OP_DIR    = 4'd8;
	localparam logic [OP_W-1:0] OP_MULT   = 4'd9;
	localparam logic [OP_W-1:0] OP_TEST   = 4'd10;
	localparam logic [OP_W-1:0] OP_CEIL   = 4'd11;
	localparam logic [OP_W-1:0] OP_TOP    = 4'd12;
	localparam logic [OP_W-1:0] OP_EMIT   = 4'd13;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} grc_cmd_t;

	typedef struct packed {
		logic div_done;
		logic red_ok;
		logic second;
		logic march_done;
		logic emit_space;
		logic last_row;
	} grc_sts_t;

endpackage

// ----- rtl/core/grc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module grc_div
	import grc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic [DIV_NUM_W-1:0] quo,
	output logic                 done
);

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   part;
	logic [DIV_DEN_W+1:0] trial;
	logic                 ge;

	assign part  = {rem_q, quo_q[DIV_NUM_W-1]};
	assign trial = {1'b0, part} - {2'b00, den_q};
	assign ge    = ~trial[DIV_DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? trial[DIV_DEN_W-1:0] : part[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ----- rtl/core/grc_datapath.sv -----
// Datapath: config registers, angle and sine evaluation, ray march, ceiling division, row shading, output register.
module grc_datapath
	import grc_pkg::*;
#(
	parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF,
	parameter int MAP_COLUMNS    = MAP_COLUMNS_DEF,
	parameter int MAP_ROWS       = MAP_ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  grc_cmd_t              cmd,
	output grc_sts_t              sts,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [COL_W-1:0]      column,
	input  logic [ANGLE_W-1:0]    view_angle,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COL_W-1:0]      out_column,
	output logic [ROW_W-1:0]      row,
	output logic [GLYPH_W-1:0]    glyph,
	output logic [COLOR_W-1:0]    color,
	output logic                  last
);

	localparam int HALF_ROWS = SCREEN_ROWS / 2;

	logic [POS_W-1:0] px_q, py_q;
	logic [MAP_W-1:0] map_q;

	logic [COL_W-1:0]          col_q;
	logic [ANGLE_W-1:0]        va_q;
	logic signed [ARG_W-1:0]   ang_q, arg_q;
	logic [16:0]               s_q;
	logic [19:0]               f_q;
	logic [13:0]               q6_q;
	logic [12:0]               q120_q;
	logic signed [TRIG_W-1:0]  p_q, dir_x_q, dir_y_q;
	logic                      sel_q;
	logic [DIST_W-1:0]         travel_q;
	logic signed [34:0]        prod_x_s1, prod_y_s1;
	logic [ROW_CNT_W-1:0]      top_q, row_q;
	logic [ROW_CNT_W:0]        bot_q;
	logic [GLYPH_W-1:0]        wall_glyph_q;

	logic                      out_valid_q, out_last_q;
	logic [COL_W-1:0]          out_col_q;
	logic [ROW_W-1:0]          out_row_q;
	logic [GLYPH_W-1:0]        out_glyph_q;
	logic [COLOR_W-1:0]        out_color_q;

	logic                      div_start, div_done;
	logic [DIV_NUM_W-1:0]      div_num, div_quo;
	logic [DIV_DEN_W-1:0]      div_den;

	logic [COL_OFS_W-1:0]      col_ofs_tbl [2**COL_W];
	logic [COL_OFS_W-1:0]      col_ofs;
	logic [34:0]               q6_prod;
	logic [40:0]               q120_prod;

	logic signed [TRIG_W-1:0]  a17;
	logic signed [33:0]        sq, dp;
	logic [33:0]               ff;
	logic signed [TRIG_W-1:0]  p_c;
	logic signed [ARG_W-1:0]   ang_c;
	logic signed [ARG_W-1:0]   pos_x, pos_y;
	logic                      out_x, out_y, wall, march_done;
	logic [10:0]               cell_x, cell_y;
	logic [2:0]                cx, cy;
	logic [5:0]                bit_idx;
	logic [DIST_W:0]           travel_inc;
	logic                      emit_space, last_row;
	logic [ROW_CNT_W-1:0]      top_c;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q  <= PLAYER_X_RST;
			py_q  <= PLAYER_Y_RST;
			map_q <= MAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PLAYER_X: px_q  <= cfg_data[POS_W-1:0];
				CFG_PLAYER_Y: py_q  <= cfg_data[POS_W-1:0];
				CFG_MAP:      map_q <= cfg_data[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Column angle offsets, constant per column
	for (genvar gi = 0; gi < 2**COL_W; gi++) begin : g_col_ofs
		assign col_ofs_tbl[gi] = COL_OFS_W'((gi * ANG_ONE) / SCREEN_COLUMNS);
	end
	assign col_ofs = col_ofs_tbl[col_q];

	// Ceiling divider
	assign div_start = (cmd.op == OP_CEIL);
	assign div_num   = DIV_NUM_W'(SCREEN_ROWS * CELL_ONE) + DIV_NUM_W'(travel_q)
	                 - DIV_NUM_W'(1);
	assign div_den   = travel_q;

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	// Trig arithmetic
	assign ang_c     = ARG_W'(va_q) + ARG_W'(col_ofs) - ARG_W'(ANG_HALF);
	assign a17       = arg_q[TRIG_W-1:0];
	assign sq        = a17 * a17;
	assign ff        = {17'd0, s_q} * {17'd0, s_q};
	assign q6_prod   = {18'd0, s_q} * 35'(RECIP6);
	assign q120_prod = {21'd0, f_q} * 41'(RECIP120);
	assign p_c       = TRIG_W'(ANG_ONE) - TRIG_W'(q6_q) + TRIG_W'(q120_q);
	assign dp        = a17 * p_q;

	// March test
	assign pos_x  = $signed({8'd0, px_q}) + $signed({prod_x_s1[34], prod_x_s1[34:13]});
	assign pos_y  = $signed({8'd0, py_q}) + $signed({prod_y_s1[34], prod_y_s1[34:13]});
	assign cell_x = pos_x[ARG_W-1:12];
	assign cell_y = pos_y[ARG_W-1:12];
	assign out_x  = (pos_x <= -ARG_W'(CELL_ONE))
	              || (!pos_x[ARG_W-1] && cell_x >= 11'(MAP_COLUMNS));
	assign out_y  = (pos_y <= -ARG_W'(CELL_ONE))
	              || (!pos_y[ARG_W-1] && cell_y >= 11'(MAP_ROWS));
	assign cx      = pos_x[ARG_W-1] ? 3'd0 : cell_x[2:0];
	assign cy      = pos_y[ARG_W-1] ? 3'd0 : cell_y[2:0];
	assign bit_idx = {3'd0, cy} * 6'(MAP_COLUMNS) + {3'd0, cx};
	assign wall    = (bit_idx < 6'(MAP_W)) && map_q[bit_idx[4:0]];
	assign march_done = out_x || out_y || wall || (travel_q == DIST_W'(FAR_Q));
	assign travel_inc = {1'b0, travel_q} + (DIST_W+1)'(STEP_Q);

	assign top_c = (div_quo >= DIV_NUM_W'(HALF_ROWS)) ? '0
	             : ROW_CNT_W'(DIV_NUM_W'(HALF_ROWS) - div_quo);

	assign emit_space = !out_valid_q || out_ready;
	assign last_row   = (row_q == ROW_CNT_W'(SCREEN_ROWS - 1));

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				col_q <= column;
				va_q  <= view_angle;
			end
			OP_ANG: begin
				ang_q <= ang_c;
				arg_q <= ang_c + ARG_W'(ANG_QTURN);
				sel_q <= 1'b0;
			end
			OP_RED: begin
				if (arg_q > ARG_W'(ANG_PI))
					arg_q <= arg_q - ARG_W'(ANG_2PI);
				else if (arg_q < -ARG_W'(ANG_PI))
					arg_q <= arg_q + ARG_W'(ANG_2PI);
			end
			OP_SQR:    s_q  <= sq[29:13];
			OP_FOURTH: begin
				f_q  <= ff[32:13];
				q6_q <= q6_prod[RECIP6_SH+13:RECIP6_SH];
			end
			OP_Q120:   q120_q <= q120_prod[RECIP120_SH+12:RECIP120_SH];
			OP_POLY:   p_q  <= p_c;
			OP_DIR: begin
				if (!sel_q) begin
					dir_x_q <= dp[29:13];
					arg_q   <= ang_q;
					sel_q   <= 1'b1;
				end else begin
					dir_y_q  <= dp[29:13];
					travel_q <= DIST_W'(STEP_Q);
				end
			end
			OP_MULT: begin
				prod_x_s1 <= dir_x_q * $signed({1'b0, travel_q});
				prod_y_s1 <= dir_y_q * $signed({1'b0, travel_q});
			end
			OP_TEST: begin
				if (out_x || out_y)
					travel_q <= DIST_W'(FAR_Q);
				else if (!march_done)
					travel_q <= (travel_inc > (DIST_W+1)'(FAR_Q)) ? DIST_W'(FAR_Q)
					          : travel_inc[DIST_W-1:0];
			end
			OP_TOP: begin
				top_q <= top_c;
				bot_q <= (ROW_CNT_W+1)'(SCREEN_ROWS) - {1'b0, top_c};
				row_q <= '0;
				if (travel_q <= DIST_W'(SHADE_NEAR))
					wall_glyph_q <= GLYPH_HASH;
				else if (travel_q <= DIST_W'(SHADE_MID))
					wall_glyph_q <= GLYPH_BIGO;
				else if (travel_q <= DIST_W'(SHADE_FAR))
					wall_glyph_q <= GLYPH_SMALLO;
				else
					wall_glyph_q <= GLYPH_DOT;
			end
			OP_EMIT: begin
				if (emit_space)
					row_q <= row_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.op == OP_EMIT && emit_space)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_EMIT && emit_space) begin
			out_col_q  <= col_q;
			out_row_q  <= row_q[ROW_W-1:0];
			out_last_q <= last_row;
			if (row_q < top_q) begin
				out_glyph_q <= GLYPH_SPACE;
				out_color_q <= COLOR_SKY;
			end else if ({1'b0, row_q} < bot_q) begin
				out_glyph_q <= wall_glyph_q;
				out_color_q <= COLOR_WALL;
			end else begin
				out_glyph_q <= GLYPH_DOT;
				out_color_q <= COLOR_FLOOR;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_column = out_col_q;
	assign row        = out_row_q;
	assign glyph      = out_glyph_q;
	assign color      = out_color_q;
	assign last       = out_last_q;

	assign sts.div_done   = div_done;
	assign sts.red_ok     = (arg_q <= ARG_W'(ANG_PI)) && (arg_q >= -ARG_W'(ANG_PI));
	assign sts.second     = sel_q;
	assign sts.march_done = march_done;
	assign sts.emit_space = emit_space;
	assign sts.last_row   = last_row;

`ifndef SYNTHESIS
	a_first_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_DIR && sel_q) |=> (travel_q == DIST_W'(STEP_Q)))
		else $error("march did not start at one step");
	a_travel_cap: assert property (@(posedge clk) disable iff (!arst_n)
		($past(cmd.op) == OP_TEST) |-> (travel_q <= DIST_W'(FAR_Q)))
		else $error("distance beyond far limit");
	a_cell_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((out_color_q == COLOR_SKY && out_glyph_q == GLYPH_SPACE)
		|| out_color_q == COLOR_WALL
		|| (out_color_q == COLOR_FLOOR && out_glyph_q == GLYPH_DOT)))
		else $error("glyph and colour disagree");
`endif

endmodule

// ----- rtl/core/grc_ctrl.sv -----
// Controller: sequences angle, sine, march, division and row emission for one column.
module grc_ctrl
	import grc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  grc_sts_t sts,
	output grc_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_ANG    = 4'd1;
	localparam logic [3:0] ST_RED    = 4'd2;
	localparam logic [3:0] ST_SQR    = 4'd3;
	localparam logic [3:0] ST_FOURTH = 4'd4;
	localparam logic [3:0] ST_Q120   = 4'd5;
	localparam logic [3:0] ST_POLY   = 4'd6;
	localparam logic [3:0] ST_DIR    = 4'd7;
	localparam logic [3:0] ST_MULT   = 4'd8;
	localparam logic [3:0] ST_TEST   = 4'd9;
	localparam logic [3:0] ST_CEIL   = 4'd10;
	localparam logic [3:0] ST_CWAIT  = 4'd11;
	localparam logic [3:0] ST_EMIT   = 4'd12;

	logic [3:0] st_q, st_d;

	always_comb begin
		st_d   = st_q;
		cmd.op = OP_NOP;
		in_ready = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = OP_LOAD;
					st_d   = ST_ANG;
				end
			end
			ST_ANG: begin
				cmd.op = OP_ANG;
				st_d   = ST_RED;
			end
			ST_RED: begin
				cmd.op = OP_RED;
				if (sts.red_ok)
					st_d = ST_SQR;
			end
			ST_SQR: begin
				cmd.op = OP_SQR;
				st_d   = ST_FOURTH;
			end
			ST_FOURTH: begin
				cmd.op = OP_FOURTH;
				st_d   = ST_Q120;
			end
			ST_Q120: begin
				cmd.op = OP_Q120;
				st_d   = ST_POLY;
			end
			ST_POLY: begin
				cmd.op = OP_POLY;
				st_d   = ST_DIR;
			end
			ST_DIR: begin
				cmd.op = OP_DIR;
				st_d   = sts.second ? ST_MULT : ST_RED;
			end
			ST_MULT: begin
				cmd.op = OP_MULT;
				st_d   = ST_TEST;
			end
			ST_TEST: begin
				cmd.op = OP_TEST;
				st_d   = sts.march_done ? ST_CEIL : ST_MULT;
			end
			ST_CEIL: begin
				cmd.op = OP_CEIL;
				st_d   = ST_CWAIT;
			end
			ST_CWAIT: begin
				if (sts.div_done) begin
					cmd.op = OP_TOP;
					st_d   = ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.op = OP_EMIT;
				if (sts.emit_space && sts.last_row)
					st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else
			st_q <= st_d;
	end

endmodule

// ----- rtl/core/grid_raycast_column_renderer.sv -----
// Top level of the grid ray-cast column renderer.
// One column is taken at a time: a beat on the input starts the work and the block
// takes the next beat only after the last of its SCREEN_ROWS cells has been loaded
// into the output register. A column is accepted, its angle formed, the cosine and
// then the sine evaluated, each after its range-reduction passes (at most two passes
// for the cosine and one for the sine with the default sizes), the ray marched (up to
// 160 march steps), the ceiling division done and one output cell emitted per cycle
// when the sink keeps up.
// Configuration writes take effect at once and are meant for idle periods.
module grid_raycast_column_renderer
	import grc_pkg::*;
#(
	parameter int SCREEN_COLUMNS = SCREEN_COLUMNS_DEF,
	parameter int SCREEN_ROWS    = SCREEN_ROWS_DEF,
	parameter int MAP_COLUMNS    = MAP_COLUMNS_DEF,
	parameter int MAP_ROWS       = MAP_ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COL_W-1:0]      column,
	input  logic [ANGLE_W-1:0]    view_angle,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COL_W-1:0]      out_column,
	output logic [ROW_W-1:0]      row,
	output logic [GLYPH_W-1:0]    glyph,
	output logic [COLOR_W-1:0]    color,
	output logic                  last
);

	grc_cmd_t cmd;
	grc_sts_t sts;

	grc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	grc_datapath #(
		.SCREEN_COLUMNS (SCREEN_COLUMNS),
		.SCREEN_ROWS    (SCREEN_ROWS),
		.MAP_COLUMNS    (MAP_COLUMNS),
		.MAP_ROWS       (MAP_ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.column     (column),
		.view_angle (view_angle),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_column (out_column),
		.row        (row),
		.glyph      (glyph),
		.color      (color),
		.last       (last)
	);

endmodule
